/* rtl/core/minstd_keystream_header_decrypt_macros.svh */
// Assertion macros for the keystream header decryptor checker.
`ifndef MINSTD_KEYSTREAM_HEADER_DECRYPT_MACROS_SVH
`define MINSTD_KEYSTREAM_HEADER_DECRYPT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define MKHD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define MKHD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/core/mkhd_pkg.sv */
// Shared types and constants for the keystream header decryptor.
`timescale 1ns / 1ps
package mkhd_pkg;

   localparam int unsigned KEY_W  = 31;
   localparam int unsigned PROD_W = 47;
   localparam int unsigned POS_W  = 6;

   localparam logic [15:0]      MULTIPLIER  = 16'd48271;
   localparam logic [KEY_W-1:0] MODULUS     = 31'h7FFF_FFFF;
   localparam logic [POS_W-1:0] OFFSET_POS  = 6'h20;
   localparam logic [POS_W-1:0] SIZE_POS    = 6'h24;
   localparam logic [POS_W-1:0] RECORD_LEN  = 6'h28;
   localparam logic [POS_W-1:0] RECORD_LAST = RECORD_LEN - 6'd1;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_BYTE  = 1'b1;

   typedef enum logic [1:0] {
      KIND_NAME   = 2'd0,
      KIND_OFFSET = 2'd1,
      KIND_SIZE   = 2'd2
   } field_kind_type;

   // Per-cycle control from the top level to the state-holding units.
   typedef struct packed {
      logic start;    // start beat leaves the input register
      logic advance;  // byte beat leaves the input register
   } stream_ctrl_type;

   typedef struct packed {
      field_kind_type kind;
      logic           kept;
      logic           done;
      logic [31:0]    offset;
      logic [31:0]    size;
   } record_fields_type;

endpackage

/* rtl/core/minstd_keystream_header_decrypt.sv */
// Top level of the keystream header decryptor.
`timescale 1ns / 1ps
// Decrypts archive directory records, one byte per beat.
// req channel: tuser selects the beat kind (0 start, 1 byte). A start beat
//   loads the key from tdata[15:0] (file count) and rewinds the record; it
//   produces no result. A byte beat carries the cipher byte in tdata[23:16].
// rsp channel: one beat per byte beat: plain byte, field kind, name-kept flag,
//   tlast on the 40th byte of a record, with offset and size on that beat
//   (zero on all others). Records run back to back without new start beats.
// Path: an accepted byte beat is held in the input register, decrypted
//   combinationally and written to the result register, which presents it.
// Throughput: one beat per cycle while rsp_tready allows; the key update (multiply,
//   Mersenne fold) is a combinational loop on the key register, mod 255 outside it.
// Stall: the result register holds while rsp_tready is low; the input
//   register still takes one more beat, then req_tready drops. Start beats
//   pass even while a result waits.
// Reset: synchronous, active high; clears the valid flags of both beat registers,
//   the key, the record position and the assembled offset and size.
module minstd_keystream_header_decrypt
   import mkhd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] seed, [23:16] cipher_byte
   input  logic        req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [7:0] plain_byte, [39:8] entry_offset, [71:40] entry_size
   output logic [2:0]  rsp_tuser,   // [1:0] field_kind, [2] name_char_kept
   output logic        rsp_tlast    // record_done
);

   // input beat register
   logic        in_valid_ff, in_valid_in;
   logic        in_type_ff;
   logic [15:0] in_seed_ff;
   logic [7:0]  in_byte_ff;

   // result beat register
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_plain_ff;
   record_fields_type out_fields_ff;

   stream_ctrl_type   ctrl;
   logic              out_free;
   logic              req_take;
   logic [7:0]        ks_byte;
   logic [7:0]        plain_byte;
   record_fields_type fields;

   assign out_free     = !out_valid_ff || rsp_tready;
   assign ctrl.start   = in_valid_ff && (in_type_ff == REQ_START);
   assign ctrl.advance = in_valid_ff && (in_type_ff == REQ_BYTE) && out_free;
   assign req_tready   = !in_valid_ff || ctrl.start || ctrl.advance;
   assign req_take     = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !ctrl.start && !ctrl.advance);
   assign out_valid_in = ctrl.advance || (out_valid_ff && !rsp_tready);

   assign plain_byte = in_byte_ff ^ ks_byte;

   mkhd_keygen u_keygen (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .seed    (in_seed_ff),
      .ks_byte (ks_byte)
   );

   mkhd_record u_record (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .plain_byte (plain_byte),
      .fields     (fields)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_type_ff <= req_tuser;
         in_seed_ff <= req_tdata[15:0];
         in_byte_ff <= req_tdata[23:16];
      end
      if (ctrl.advance) begin
         out_plain_ff  <= plain_byte;
         out_fields_ff <= fields;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_fields_ff.size, out_fields_ff.offset, out_plain_ff};
   assign rsp_tuser  = {out_fields_ff.kept, out_fields_ff.kind};
   assign rsp_tlast  = out_fields_ff.done;

endmodule

/* rtl/core/mkhd_keygen.sv */
// Minimal-standard generator state and keystream byte (key mod 255).
`timescale 1ns / 1ps
module mkhd_keygen
   import mkhd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  stream_ctrl_type ctrl,
   input  logic [15:0]     seed,
   output logic [7:0]      ks_byte
);

   logic [KEY_W-1:0]  key_ff;
   logic [KEY_W-1:0]  key_in;
   logic [KEY_W-1:0]  key_next;
   logic [PROD_W-1:0] product;
   logic [31:0]       folded;
   logic [31:0]       reduced;

   // Sum of base-256 digits, then fold, then one conditional subtract.
   function automatic logic [7:0] mod255(input logic [KEY_W-1:0] v);
      logic [9:0] sum;
      logic [8:0] fold;
      sum  = 10'(v[7:0]) + 10'(v[15:8]) + 10'(v[23:16]) + 10'(v[30:24]);
      fold = 9'(sum[7:0]) + 9'(sum[9:8]);
      if (fold >= 9'd255) begin
         fold = fold - 9'd255;
      end
      return fold[7:0];
   endfunction

   // 48271 * key mod (2^31-1) by Mersenne folding; a zero residue maps to 2^31-1.
   always_comb begin
      product = PROD_W'(key_ff) * PROD_W'(MULTIPLIER);
      folded  = {1'b0, product[KEY_W-1:0]} + 32'(product[PROD_W-1:KEY_W]);
      reduced = (folded >= {1'b0, MODULUS}) ? folded - {1'b0, MODULUS} : folded;
      key_next = (reduced[KEY_W-1:0] == '0) ? MODULUS : reduced[KEY_W-1:0];
   end

   assign ks_byte = mod255(key_next);

   always_comb begin
      key_in = key_ff;
      if (ctrl.start) begin
         key_in = KEY_W'(seed);
      end else if (ctrl.advance) begin
         key_in = key_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

endmodule

/* rtl/core/mkhd_record.sv */
// Record position tracking and offset/size assembly.
`timescale 1ns / 1ps
module mkhd_record
   import mkhd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  stream_ctrl_type   ctrl,
   input  logic [7:0]        plain_byte,
   output record_fields_type fields
);

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic [31:0]      offset_ff;
   logic [31:0]      offset_in;
   logic [23:0]      size_ff;
   logic [23:0]      size_in;
   logic [POS_W-1:0] pos;
   logic [1:0]       lane;

   assign pos  = (pos_ff >= RECORD_LEN) ? '0 : pos_ff;
   assign lane = pos[1:0];   // byte lane within offset or size word

   always_comb begin
      fields        = '0;
      fields.kind   = KIND_NAME;
      offset_in     = offset_ff;
      size_in       = size_ff;
      pos_in        = pos_ff;

      if (pos < OFFSET_POS) begin
         fields.kind = KIND_NAME;
         fields.kept = (plain_byte != 8'd0);
      end else if (pos < SIZE_POS) begin
         fields.kind = KIND_OFFSET;
         case (lane)
            2'd0:    offset_in[7:0]   = offset_ff[7:0]   | plain_byte;
            2'd1:    offset_in[15:8]  = offset_ff[15:8]  | plain_byte;
            2'd2:    offset_in[23:16] = offset_ff[23:16] | plain_byte;
            default: offset_in[31:24] = offset_ff[31:24] | plain_byte;
         endcase
      end else begin
         fields.kind = KIND_SIZE;
         if (pos == RECORD_LAST) begin
            fields.done   = 1'b1;
            fields.offset = offset_ff;
            fields.size   = {plain_byte, size_ff};
         end else begin
            case (lane)
               2'd0:    size_in[7:0]   = size_ff[7:0]   | plain_byte;
               2'd1:    size_in[15:8]  = size_ff[15:8]  | plain_byte;
               2'd2:    size_in[23:16] = size_ff[23:16] | plain_byte;
               default: size_in        = size_ff;
            endcase
         end
      end

      if (fields.done) begin
         pos_in    = '0;
         offset_in = '0;
         size_in   = '0;
      end else begin
         pos_in = pos + 6'd1;
      end

      if (ctrl.start) begin
         pos_in    = '0;
         offset_in = '0;
         size_in   = '0;
      end else if (!ctrl.advance) begin
         pos_in    = pos_ff;
         offset_in = offset_ff;
         size_in   = size_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         offset_ff <= '0;
         size_ff   <= '0;
      end else begin
         pos_ff    <= pos_in;
         offset_ff <= offset_in;
         size_ff   <= size_in;
      end
   end

endmodule

/* rtl/core/mkhd_checker.sv */
// Port-level checker for the keystream header decryptor, with its bind.
`timescale 1ns / 1ps
`include "minstd_keystream_header_decrypt_macros.svh"
module mkhd_checker
   import mkhd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   `MKHD_ASSERT_ALWAYS(a_idle_after_reset, reset |=> !rsp_tvalid, "result beat straight after reset")
   `MKHD_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result beat changed")
   `MKHD_ASSERT(a_last_is_size, rsp_tvalid && rsp_tlast |-> rsp_tuser[1:0] == KIND_SIZE, "record end not on a size byte")
   `MKHD_ASSERT(a_kept_name, rsp_tvalid && rsp_tuser[1:0] == KIND_NAME |-> rsp_tuser[2] == (rsp_tdata[7:0] != 8'd0), "name kept flag wrong")
   `MKHD_ASSERT(a_fields_zero, rsp_tvalid && !rsp_tlast |-> rsp_tdata[71:8] == 64'd0 && !(rsp_tuser[2] && rsp_tuser[1:0] != KIND_NAME), "offset or size outside record end")

endmodule

bind minstd_keystream_header_decrypt mkhd_checker u_mkhd_checker (.*);

/* bench/tb_top.sv */
// Self-checking bench for the keystream header decryptor.
`timescale 1ns / 1ps
module tb_top;
   import mkhd_pkg::*;

   localparam int HALF_PERIOD  = 1;     // 2 ns clock period
   localparam int RESET_CYCLES = 10;
   localparam int STALL_LIMIT  = 2000;  // cycles with no beat on either side
   localparam int DRAIN_CYCLES = 8;     // leave slack after the queue drains
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int MAX_REPORTS  = 100;
   localparam logic [KEY_W-1:0] PAD_MOD = 31'd255;

   typedef struct {
      logic [7:0]     plain;
      field_kind_type kind;
      logic           kept;
      logic           done;
      logic [31:0]    offset;
      logic [31:0]    size;
   } dir_beat_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic        req_tuser  = REQ_START;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   // Idling knobs (percent per cycle), receiver hold-off and run counters
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_off       = 0;
   int items_sent     = 0;
   int fail_count     = 0;
   int quiet_cycles   = 0;

   // Decryptor state as predicted
   logic [KEY_W-1:0] key_state  = '0;
   logic [POS_W-1:0] rec_pos    = '0;
   logic [31:0]      offset_acc = '0;
   logic [23:0]      size_acc   = '0;
   dir_beat_type     beats_due[$];

   always #HALF_PERIOD clock = ~clock;

   minstd_keystream_header_decrypt i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 48271 * key mod (2^31-1); a zero remainder maps to the modulus itself,
   // which covers the zero key and the fixed point at 2^31-1.
   function automatic logic [KEY_W-1:0] step_key(input logic [KEY_W-1:0] k);
      longint unsigned prod;
      prod = (64'(MULTIPLIER) * 64'(k)) % 64'(MODULUS);
      if (prod == 0) prod = 64'(MODULUS);
      return prod[KEY_W-1:0];
   endfunction

   function automatic logic [7:0] pad_byte(input logic [KEY_W-1:0] k);
      return 8'(k % PAD_MOD);
   endfunction

   task automatic decrypt_model(input logic beat_kind, input logic [15:0] seed,
                                input logic [7:0] cipher);
      dir_beat_type b;
      if (beat_kind == REQ_START) begin
         key_state  = KEY_W'(seed);
         rec_pos    = '0;
         offset_acc = '0;
         size_acc   = '0;
         return;
      end
      key_state = step_key(key_state);
      b.plain  = pad_byte(key_state) ^ cipher;
      b.kept   = 1'b0;
      b.done   = 1'b0;
      b.offset = '0;
      b.size   = '0;
      if (rec_pos < OFFSET_POS) begin
         b.kind = KIND_NAME;
         b.kept = (b.plain != 8'h00);
      end else if (rec_pos < SIZE_POS) begin
         b.kind = KIND_OFFSET;
         offset_acc[8*(rec_pos-OFFSET_POS) +: 8] = b.plain;
      end else begin
         b.kind = KIND_SIZE;
         if (rec_pos == RECORD_LAST) begin
            b.done   = 1'b1;
            b.offset = offset_acc;
            b.size   = {b.plain, size_acc};
         end else begin
            size_acc[8*(rec_pos-SIZE_POS) +: 8] = b.plain;
         end
      end
      if (b.done) begin
         rec_pos    = '0;
         offset_acc = '0;
         size_acc   = '0;
      end else begin
         rec_pos = rec_pos + 1'b1;
      end
      beats_due.push_back(b);
   endtask

   // One request beat; valid stays high between back-to-back beats.
   task automatic send_beat(input logic beat_kind, input logic [15:0] seed,
                            input logic [7:0] cipher);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 24'($urandom);
         req_tuser  <= 1'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= beat_kind;
      req_tdata  <= {cipher, seed};
      do @(posedge clock); while (!req_tready);
      decrypt_model(beat_kind, seed, cipher);
      items_sent++;
   endtask

   task automatic send_start(input logic [15:0] seed);
      send_beat(REQ_START, seed, 8'($urandom));
   endtask

   task automatic send_byte(input logic [7:0] cipher);
      send_beat(REQ_BYTE, 16'($urandom), cipher);
   endtask

   // Encrypt a chosen plain byte with the next pad byte
   task automatic send_plain(input logic [7:0] plain);
      send_byte(plain ^ pad_byte(step_key(key_state)));
   endtask

   function automatic logic [7:0] pick_plain();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_seed();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(1, 15));
         default: return 16'($urandom);
      endcase
   endfunction

   // Bytes of one record from its current position; stops early at stop_at
   task automatic send_record(input int stop_at);
      for (int p = 0; p < 40 && p < stop_at; p++) send_plain(pick_plain());
   endtask

   // Mostly well-formed archives, some cut short, some plain noise
   task automatic random_traffic(input int n_items);
      int target;
      int pick;
      target = items_sent + n_items;
      while (items_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            send_beat(1'($urandom), 16'($urandom), 8'($urandom));
         end else if (pick < 25) begin
            send_start(pick_seed());
            send_record($urandom_range(0, 39));
         end else begin
            send_start(pick_seed());
            repeat ($urandom_range(1, 3)) send_record(40);
         end
      end
   endtask

   task automatic wait_drained();
      while (beats_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      // bytes ahead of any start run on the reset key of zero
      send_byte(8'h00);
      send_byte(8'hFF);
      // zero seed: key jumps to 2^31-1 and sticks there
      send_start(16'h0000);
      send_byte(8'hA5);
      send_plain(8'h00);
      send_byte(8'h5A);
      send_start(16'hFFFF);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_plain(8'h00);
      send_plain(8'hFF);
      send_start(16'h0001);
      send_plain(8'h01);
      send_plain(8'h80);
      send_start(16'h8000);
      send_byte(8'h3C);
      // restart part-way through a record
      send_start(16'h00FF);
      send_byte(8'hC3);
   endtask

   // Two records with no start between: all-ones then all-zero offset/size
   task automatic test_back_to_back_records();
      send_start(pick_seed());
      for (int p = 0; p < 80; p++) begin
         if (p % 40 < 32)  send_plain(pick_plain());
         else if (p < 40)  send_plain(8'hFF);
         else              send_plain(8'h00);
      end
   endtask

   // Receiver holds off while the sender keeps pushing: input must stall
   task automatic test_output_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off       = HOLD_CYCLES;
      send_start(pick_seed());
      send_record(40);
      send_record(40);
   endtask

   task automatic test_no_idle();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      random_traffic(360);
   endtask

   task automatic test_sender_idle();
      send_idle_pct  = 85;
      recv_stall_pct = 0;
      random_traffic(360);
   endtask

   task automatic test_receiver_stall();
      send_idle_pct  = 0;
      recv_stall_pct = 85;
      random_traffic(360);
   endtask

   task automatic test_both_idle();
      send_idle_pct  = 16;
      recv_stall_pct = 16;
      random_traffic(360);
   endtask

   // Result side ready, with its own hold-off counter
   always @(posedge clock) begin
      if (hold_off > 0) begin
         rsp_tready <= 1'b0;
         hold_off--;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         if (fail_count < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      dir_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (beats_due.size() == 0) begin
            if (fail_count < MAX_REPORTS)
               $display("%0t: unexpected result beat, expected none, actual %0h",
                        $time, rsp_tdata);
            fail_count++;
         end else begin
            want = beats_due.pop_front();
            compare_field("plain_byte",     want.plain,  rsp_tdata[7:0]);
            compare_field("field_kind",     want.kind,   rsp_tuser[1:0]);
            compare_field("name_char_kept", want.kept,   rsp_tuser[2]);
            compare_field("record_done",    want.done,   rsp_tlast);
            compare_field("entry_offset",   want.offset, rsp_tdata[39:8]);
            compare_field("entry_size",     want.size,   rsp_tdata[71:40]);
         end
      end
   end

   // Watchdog: too long with no beat moving on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_back_to_back_records();
      test_output_backpressure();
      test_no_idle();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

/* minstd_keystream_header_decrypt.f */
+incdir+rtl/core
rtl/core/mkhd_pkg.sv
rtl/core/mkhd_keygen.sv
rtl/core/mkhd_record.sv
rtl/core/minstd_keystream_header_decrypt.sv
rtl/core/mkhd_checker.sv
bench/tb_top.sv
